>>> sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned MaxUnits  = 3;

  localparam logic [7:0]  LeadTwoLo   = 8'hC2;
  localparam logic [7:0]  LeadTwoHi   = 8'hDF;
  localparam logic [7:0]  LeadFourHi  = 8'hF4;
  localparam logic [20:0] MinThree    = 21'h000800;
  localparam logic [20:0] MinFour     = 21'h010000;
  localparam logic [20:0] MaxCode     = 21'h10FFFF;
  localparam logic [20:0] SurrLo      = 21'h00D800;
  localparam logic [20:0] SurrHi      = 21'h00DFFF;
  localparam logic [5:0]  HighSurrTag = 6'b110110;
  localparam logic [5:0]  LowSurrTag  = 6'b110111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        invalid;
    logic        end_of_string;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  pending;
    logic [1:0]  seq_len;
    logic [20:0] acc;
    logic        discarding;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]                count;
    out_word_t [MaxUnits-1:0]  units;
  } step_res_t;

endpackage

>>> sv/u8u16_step.sv
// Per-byte decode: sequence state update and the result words for one byte.
module u8u16_step (
  input  u8u16_pkg::seq_state_t st_i,
  input  u8u16_pkg::in_word_t   in_i,
  output u8u16_pkg::seq_state_t st_o,
  output u8u16_pkg::step_res_t  res_o
);
  import u8u16_pkg::*;

  logic [7:0]  b;
  logic        last;
  logic        bad;
  logic [1:0]  len;
  logic [1:0]  pend;
  logic [20:0] acc;
  logic [19:0] ofs;
  logic        range_bad;

  assign b    = in_i.data_byte;
  assign last = in_i.final_byte;
  assign ofs  = 20'(acc - MinFour);

  always_comb begin
    bad = 1'b0;
    len = st_i.seq_len;
    pend = st_i.pending;
    acc = st_i.acc;
    if (st_i.pending == 2'd0) begin
      if (b[7] == 1'b0) begin
        acc = {13'd0, b};
        len = 2'd0;
      end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
        acc = {16'd0, b[4:0]};
        len = 2'd1;
      end else if (b[7:4] == 4'hE) begin
        acc = {17'd0, b[3:0]};
        len = 2'd2;
      end else if (b[7:4] == 4'hF && b <= LeadFourHi) begin
        acc = {18'd0, b[2:0]};
        len = 2'd3;
      end else begin
        bad = 1'b1;
      end
      pend = len;
    end else begin
      bad  = (b[7:6] != 2'b10);
      acc  = {st_i.acc[14:0], b[5:0]};
      pend = st_i.pending - 2'd1;
    end
  end

  assign range_bad = (len == 2'd2 && acc < MinThree) ||
                     (len == 2'd3 && acc < MinFour) ||
                     (acc > MaxCode) ||
                     (acc >= SurrLo && acc <= SurrHi) ||
                     (acc == 21'd0);

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    if (st_i.discarding) begin
      st_o.discarding = !last;
    end else if (bad || (pend != 2'd0 && last) || (pend == 2'd0 && range_bad)) begin
      st_o = '0;
      st_o.discarding = !last;
      res_o.count = 2'd1;
      res_o.units[0] = '{code_unit: 16'd0, invalid: 1'b1, end_of_string: 1'b1};
    end else if (pend != 2'd0) begin
      st_o.pending = pend;
      st_o.seq_len = len;
      st_o.acc     = acc;
    end else begin
      st_o = '0;
      if (acc[20:16] == 5'd0) begin
        res_o.units[0] = '{code_unit: acc[15:0], invalid: 1'b0, end_of_string: 1'b0};
        res_o.units[1] = '{code_unit: 16'd0, invalid: 1'b0, end_of_string: 1'b1};
        res_o.count    = last ? 2'd2 : 2'd1;
      end else begin
        res_o.units[0] = '{code_unit: {HighSurrTag, ofs[19:10]}, invalid: 1'b0,
                           end_of_string: 1'b0};
        res_o.units[1] = '{code_unit: {LowSurrTag, ofs[9:0]}, invalid: 1'b0,
                           end_of_string: 1'b0};
        res_o.units[2] = '{code_unit: 16'd0, invalid: 1'b0, end_of_string: 1'b1};
        res_o.count    = last ? 2'd3 : 2'd2;
      end
    end
  end

endmodule

>>> sv/u8u16_fifo.sv
// Result queue: takes up to three words a cycle, gives one when popped.
module u8u16_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u8u16_pkg::step_res_t push_i,
  input  logic                 pop_i,
  output logic                 room_o,
  output logic                 valid_o,
  output u8u16_pkg::out_word_t head_o
);
  import u8u16_pkg::*;

  out_word_t         mem_q [FifoDepth];
  logic [FifoAw-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [FifoAw:0]   cnt_q, cnt_d;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= (FifoAw+1)'(FifoDepth - MaxUnits));

  assign wr_d  = wr_q + FifoAw'(push_i.count);
  assign rd_d  = rd_q + FifoAw'(pop);
  assign cnt_d = cnt_q + (FifoAw+1)'(push_i.count) - (FifoAw+1)'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxUnits; k++) begin
      if (k < int'(push_i.count)) begin
        mem_q[wr_q + FifoAw'(k)] <= push_i.units[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/utf8_to_utf16_validating_decoder_core.sv
// Top level of the validating UTF-8 to UTF-16 decoder.
// Input channel: one UTF-8 byte per word with a flag on the string's final byte.
// Output channel: one UTF-16 unit per word, with invalid and end_of_string flags.
// A valid string ends with a zero unit marked end_of_string. A malformed string
// gives one word marked invalid and end_of_string; bytes up to the final one
// are then dropped, and units already sent for that string must be discarded.
// A byte is held in the input register and its first word is then written to the
// queue, from which it is presented; a queue without room holds the byte back.
// Throughput: one byte per cycle; a byte gives up to three words (surrogate
// pair plus terminator), drained one per cycle through an eight-word queue.
// The input register advances only when the queue has room for three words,
// so the output rate of one word per cycle sets the sustained byte rate.
// Reset empties the queue and the input register and clears sequence state.
// A stall on the output holds the head word; the input stalls once the queue
// lacks room for three words.
module utf8_to_utf16_validating_decoder_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  u8u16_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output u8u16_pkg::out_word_t out_data_o
);
  import u8u16_pkg::*;

  in_word_t   s1_q;
  logic       s1_valid_q, s1_valid_d;
  seq_state_t st_q, st_d, st_nxt;
  step_res_t  res, push;
  logic       room, go, accept;

  assign go         = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !go);
  assign st_d       = go ? st_nxt : st_q;

  always_comb begin
    push = res;
    if (!go) begin
      push.count = 2'd0;
    end
  end

  u8u16_step u_step (
    .st_i  (st_q),
    .in_i  (s1_q),
    .st_o  (st_nxt),
    .res_o (res)
  );

  u8u16_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (out_data_o)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      st_q       <= st_d;
    end
  end

endmodule

>>> sv/u8u16_chk.sv
// Port-level checks on the decoder's output channel, bound to the top level.
module u8u16_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input u8u16_pkg::out_word_t out_data_o
);
  import u8u16_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid |-> out_data_o.end_of_string)
    else $error("error word not marked end of string");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid |-> out_data_o.code_unit == 16'd0)
    else $error("error word carries a code unit");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.invalid &&
    out_data_o.code_unit[15:10] == HighSurrTag
    |=> out_valid_o && out_data_o.code_unit[15:10] == LowSurrTag)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_validating_decoder_core u8u16_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
